@@ rtl/tamp_pkg.sv @@
// Shared constants, types and helpers for the three-axis motion profile block.
`default_nettype none
package tamp_pkg;
    localparam int AXES_DEF      = 3;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_AXES      = 3;

    localparam logic [30:0] ACCEL_RST = 31'd13763;
    localparam logic [30:0] SPEED_RST = 31'd27525;
    localparam logic [16:0] TICK_RST  = 17'd1311;

    localparam logic [1:0] REG_ACCEL = 2'd0;
    localparam logic [1:0] REG_SPEED = 2'd1;
    localparam logic [1:0] REG_TICK  = 2'd2;

    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_LOAD    = 1'b1;

    typedef struct packed {
        logic        load;
        logic [30:0] accel_limit;
        logic [30:0] speed_limit;
        logic [16:0] tick_period;
    } lane_ctl_t;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic               done;
    } lane_res_t;

    // Clamp a 50-bit signed value into the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [49:0] x);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sd2147483647;
        lo = -50'sd2147483648;
        if (x > hi) sat32 = 32'sh7fffffff;
        else if (x < lo) sat32 = 32'sh80000000;
        else sat32 = x[31:0];
    endfunction
endpackage
`default_nettype wire

@@ rtl/tamp_lane.sv @@
// One axis lane: acceleration choice, restoring divider for braking, integration.
`default_nettype none
module tamp_lane
    import tamp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire lane_ctl_t         ctl,
    input  wire logic signed [31:0] goal,
    output logic                   busy,
    output lane_res_t              res
);
    localparam logic [33:0] NEAR_EPS = 34'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [33:0] SLOW_EPS = 34'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    typedef enum logic [2:0] {S_IDLE, S_EVAL, S_CMP, S_DIV, S_VEL, S_POS} state_t;

    state_t             state_reg;
    logic [5:0]         cnt_reg;
    logic signed [31:0] pos_reg, vel_reg, acc_reg, goal_reg;
    logic               done_reg, dpos_reg;
    logic [33:0]        ad_reg;
    logic [31:0]        av_reg;
    logic [63:0]        v2_reg;
    logic [63:0]        rhs_reg;
    logic [63:0]        quo_reg;
    logic [64:0]        rem_reg;
    logic signed [63:0] prod_reg;

    logic signed [32:0] d_w;
    logic signed [49:0] add_w;
    logic [64:0]        rem_sh;
    logic [34:0]        dv2;
    logic signed [49:0] fl_w;

    assign d_w    = 33'(goal_reg) - 33'(pos_reg);
    assign rem_sh = {rem_reg[63:0], v2_reg[63]};
    assign dv2    = {ad_reg, 1'b0};
    // floor of product / 2^FRAC_BITS via arithmetic shift
    assign fl_w   = 50'(prod_reg >>> FRAC_BITS);
    assign add_w  = fl_w + 50'(state_reg == S_VEL ? vel_reg : pos_reg);

    assign busy = (state_reg != S_IDLE);
    assign res  = '{pos: pos_reg, vel: vel_reg, acc: acc_reg, done: done_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pos_reg   <= '0;
            vel_reg   <= '0;
            acc_reg   <= '0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        goal_reg <= goal;
                        if (ctl.load == CMD_LOAD) pos_reg <= goal;
                        else state_reg <= S_EVAL;
                    end
                end
                S_EVAL:
                begin
                    ad_reg   <= d_w[32] ? 34'(-d_w) : 34'(d_w);
                    dpos_reg <= !d_w[32] && (d_w != '0);
                    av_reg   <= vel_reg[31] ? 32'(-33'(vel_reg)) : 32'(vel_reg);
                    prod_reg <= 64'(vel_reg) * 64'(vel_reg);
                    state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    if (ad_reg > NEAR_EPS)
                    begin
                        done_reg <= 1'b0;
                        v2_reg   <= 64'(prod_reg);
                        rhs_reg  <= 64'(ctl.accel_limit) * 64'(dv2);
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        cnt_reg  <= '0;
                        state_reg <= S_DIV;
                    end
                    else
                    begin
                        if (34'(av_reg) < SLOW_EPS)
                        begin
                            pos_reg <= goal_reg;
                            vel_reg <= '0;
                            acc_reg <= '0;
                            done_reg <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                S_DIV:
                begin
                    // cnt 0: choose branch; then 64 restoring steps when braking
                    if (cnt_reg == 6'd0 && rem_reg[64] == 1'b0 && quo_reg == '0
                        && v2_reg < rhs_reg)
                    begin
                        if (34'(av_reg) > 34'(ctl.speed_limit))
                            acc_reg <= '0;
                        else
                            acc_reg <= dpos_reg ? 32'(ctl.accel_limit)
                                                : -32'(ctl.accel_limit);
                        prod_reg <= '0;
                        cnt_reg <= 6'd63;
                        rem_reg[64] <= 1'b1;
                    end
                    else if (rem_reg[64] == 1'b1)
                    begin
                        prod_reg  <= 64'(acc_reg) * 64'(ctl.tick_period);
                        state_reg <= S_VEL;
                    end
                    else
                    begin
                        v2_reg <= {v2_reg[62:0], 1'b0};
                        if (rem_sh >= 65'(dv2))
                        begin
                            rem_reg <= rem_sh - 65'(dv2);
                            quo_reg <= {quo_reg[62:0], 1'b1};
                        end
                        else
                        begin
                            rem_reg <= rem_sh;
                            quo_reg <= {quo_reg[62:0], 1'b0};
                        end
                        if (cnt_reg == 6'd63)
                        begin
                            cnt_reg <= 6'd62;
                            state_reg <= S_POS;
                            prod_reg <= 64'sd1;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 6'd1;
                        end
                    end
                end
                S_POS:
                begin
                    if (cnt_reg == 6'd62)
                    begin
                        // quotient ready: clamp and sign
                        logic [63:0] q;
                        logic signed [32:0] a;
                        q = quo_reg;
                        if (q > 64'h8000_0000) q = 64'h8000_0000;
                        a = dpos_reg ? -33'(q) : 33'(q);
                        acc_reg <= sat32(50'(a));
                        cnt_reg <= 6'd61;
                    end
                    else if (cnt_reg == 6'd61)
                    begin
                        prod_reg <= 64'(acc_reg) * 64'(ctl.tick_period);
                        cnt_reg <= '0;
                        state_reg <= S_VEL;
                    end
                    else if (cnt_reg == 6'd1)
                    begin
                        prod_reg <= 64'(vel_reg) * 64'(ctl.tick_period);
                        cnt_reg <= 6'd2;
                    end
                    else
                    begin
                        pos_reg <= sat32(add_w);
                        cnt_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end
                S_VEL:
                begin
                    vel_reg <= sat32(add_w);
                    cnt_reg <= 6'd1;
                    state_reg <= S_POS;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ rtl/three_axis_motion_profile.sv @@
// Top level of the three-axis trapezoidal motion profile generator.
`default_nettype none
// Each request carries a command and one goal per axis; the block returns one result
// per request with position, velocity and acceleration of every axis plus a settled
// mask. The axes run in parallel lanes, each with its own restoring divider for the
// braking acceleration v^2/(2|d|); the slowest lane sets the time of a request. An
// advance runs evaluate and compare, then, unless every axis is near its goal, the
// acceleration choice or, for a braking axis, 64 divider steps and a clamp, then two
// multiply/integrate steps and the hand-off to the output register. The next request
// is accepted once the result has reached the output register. The result is held in
// an output register, so the next request is taken while it waits. Configuration
// registers (accel_limit, speed_limit, tick_period) may be written only while idle.
// Axes at or beyond AXES report zeros.
module three_axis_motion_profile
    import tamp_pkg::*;
#(
    parameter int AXES      = AXES_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               cmd,
    input  wire logic signed [31:0] goal_x,
    input  wire logic signed [31:0] goal_y,
    input  wire logic signed [31:0] goal_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      out_pos_x,
    output logic signed [31:0]      out_pos_y,
    output logic signed [31:0]      out_pos_z,
    output logic signed [31:0]      out_vel_x,
    output logic signed [31:0]      out_vel_y,
    output logic signed [31:0]      out_vel_z,
    output logic signed [31:0]      out_acc_x,
    output logic signed [31:0]      out_acc_y,
    output logic signed [31:0]      out_acc_z,
    output logic [2:0]              done_mask,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [30:0]        cfg_data
);
    logic [30:0] accel_reg, speed_reg;
    logic [16:0] tick_reg;
    logic        run_reg;     // lanes working on a request
    logic        pend_reg;    // lanes finished, result not yet in output register
    logic        ovalid_reg;
    lane_ctl_t   ctl;
    logic        start;
    logic signed [31:0] goals [MAX_AXES];
    lane_res_t   lres [MAX_AXES];
    logic [MAX_AXES-1:0] lbusy;
    lane_res_t   ores_reg [MAX_AXES];

    assign goals[0] = goal_x;
    assign goals[1] = goal_y;
    assign goals[2] = goal_z;

    assign in_stall = run_reg || pend_reg;
    assign start    = in_valid && !in_stall;
    assign ctl      = '{load: cmd, accel_limit: accel_reg,
                        speed_limit: speed_reg, tick_period: tick_reg};

    genvar g;
    generate
        for (g = 0; g < MAX_AXES; g++)
        begin : g_lane
            if (g < AXES)
            begin : g_on
                tamp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                    .clk(clk), .rst_n(rst_n), .start(start), .ctl(ctl),
                    .goal(goals[g]), .busy(lbusy[g]), .res(lres[g])
                );
            end
            else
            begin : g_off
                assign lbusy[g] = 1'b0;
                assign lres[g]  = '0;
            end
        end
    endgenerate

    // Control: run until all lanes idle, then move results to the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_reg  <= ACCEL_RST;
            speed_reg  <= SPEED_RST;
            tick_reg   <= TICK_RST;
            run_reg    <= 1'b0;
            pend_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ACCEL: accel_reg <= cfg_data;
                    REG_SPEED: speed_reg <= cfg_data;
                    REG_TICK:  tick_reg  <= cfg_data[16:0];
                    default:   ;
                endcase
            end
            if (start) run_reg <= 1'b1;
            else if (run_reg && lbusy == '0)
            begin
                run_reg  <= 1'b0;
                pend_reg <= 1'b1;
            end
            if (pend_reg && (!ovalid_reg || !out_stall))
            begin
                pend_reg   <= 1'b0;
                ovalid_reg <= 1'b1;
                ores_reg   <= lres;
            end
            else if (ovalid_reg && !out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = ovalid_reg;
    assign out_pos_x = ores_reg[0].pos;
    assign out_pos_y = ores_reg[1].pos;
    assign out_pos_z = ores_reg[2].pos;
    assign out_vel_x = ores_reg[0].vel;
    assign out_vel_y = ores_reg[1].vel;
    assign out_vel_z = ores_reg[2].vel;
    assign out_acc_x = ores_reg[0].acc;
    assign out_acc_y = ores_reg[1].acc;
    assign out_acc_z = ores_reg[2].acc;
    assign done_mask = {ores_reg[2].done, ores_reg[1].done, ores_reg[0].done};
endmodule
`default_nettype wire
